// File: rtl/tgfr_pkg.sv
// shared types, constants, glyph rom and helper functions for the glyph renderer
package tgfr_pkg;

    localparam int FB_WIDTH     = 128;
    localparam int FB_HEIGHT    = 64;
    localparam int MAX_SCALE    = 4;
    localparam int FB_PAGES     = (FB_HEIGHT + 7) / 8;
    localparam int FB_BYTES     = FB_WIDTH * FB_PAGES;
    localparam int FB_COL_W     = $clog2(FB_WIDTH);
    localparam int FB_PAGE_W    = (FB_PAGES > 1) ? $clog2(FB_PAGES) : 1;
    localparam int FB_ADDR_W    = $clog2(FB_BYTES);
    localparam int GLYPH_COLS   = 5;
    localparam int GLYPH_ROWS   = 7;
    localparam int GLYPH_COUNT  = 43;
    localparam int EXP_W        = GLYPH_ROWS * MAX_SCALE;
    localparam int PG_SPAN      = (EXP_W + 7 + 7) / 8;
    localparam int PG_OFF_W     = $clog2(PG_SPAN + 1);
    localparam int SHIFT_W      = 8 * (1 << PG_OFF_W);
    localparam int DX_W         = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int COORD_W      = 12;
    localparam int PITCH_W      = 6;
    localparam int MAC_A_W      = 5;
    localparam int TEXT_ADVANCE = 6;
    localparam int TAB_RESET    = 69;
    localparam int CURSOR_MAX   = 255;

    localparam logic [7:0] TAB_CODE  = 8'h09;
    localparam logic [5:0] IDX_COLON = 6'd36;
    localparam logic [5:0] IDX_DASH  = 6'd37;
    localparam logic [5:0] IDX_DOT   = 6'd38;
    localparam logic [5:0] IDX_PCT   = 6'd39;
    localparam logic [5:0] IDX_SLASH = 6'd40;
    localparam logic [5:0] IDX_SPACE = 6'd41;
    localparam logic [5:0] IDX_BOX   = 6'd42;

    localparam logic REG_TAB_COLUMN = 1'b0;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_TEXT   = 2'd1,
        REQ_SCALED = 2'd2,
        REQ_READ   = 2'd3
    } t_req_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_RD_DATA,
        S_PITCH,
        S_TOTAL,
        S_ORIGIN,
        S_XPOS,
        S_COL,
        S_READ,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  char_code;
        logic [2:0]  text_line;
        logic        line_start;
        logic [2:0]  glyph_scale;
        logic [3:0]  glyph_spacing;
        logic [4:0]  text_length;
        logic [3:0]  char_position;
        logic [5:0]  top_y;
        logic [9:0]  read_index;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       char_drawn;
    } t_res;

    typedef logic [7:0] t_glyph [GLYPH_COUNT][GLYPH_COLS];

    localparam t_glyph FONT_ROM = '{
        '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
        '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
        '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
        '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
        '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
        '{8'h7E,8'h11,8'h11,8'h11,8'h7E}, '{8'h7F,8'h49,8'h49,8'h49,8'h36},
        '{8'h3E,8'h41,8'h41,8'h41,8'h22}, '{8'h7F,8'h41,8'h41,8'h22,8'h1C},
        '{8'h7F,8'h49,8'h49,8'h49,8'h41}, '{8'h7F,8'h09,8'h09,8'h09,8'h01},
        '{8'h3E,8'h41,8'h49,8'h49,8'h7A}, '{8'h7F,8'h08,8'h08,8'h08,8'h7F},
        '{8'h00,8'h41,8'h7F,8'h41,8'h00}, '{8'h20,8'h40,8'h41,8'h3F,8'h01},
        '{8'h7F,8'h08,8'h14,8'h22,8'h41}, '{8'h7F,8'h40,8'h40,8'h40,8'h40},
        '{8'h7F,8'h02,8'h0C,8'h02,8'h7F}, '{8'h7F,8'h04,8'h08,8'h10,8'h7F},
        '{8'h3E,8'h41,8'h41,8'h41,8'h3E}, '{8'h7F,8'h09,8'h09,8'h09,8'h06},
        '{8'h3E,8'h41,8'h51,8'h21,8'h5E}, '{8'h7F,8'h09,8'h19,8'h29,8'h46},
        '{8'h46,8'h49,8'h49,8'h49,8'h31}, '{8'h01,8'h01,8'h7F,8'h01,8'h01},
        '{8'h3F,8'h40,8'h40,8'h40,8'h3F}, '{8'h1F,8'h20,8'h40,8'h20,8'h1F},
        '{8'h3F,8'h40,8'h38,8'h40,8'h3F}, '{8'h63,8'h14,8'h08,8'h14,8'h63},
        '{8'h07,8'h08,8'h70,8'h08,8'h07}, '{8'h61,8'h51,8'h49,8'h45,8'h43},
        '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
        '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h63,8'h13,8'h08,8'h64,8'h63},
        '{8'h20,8'h10,8'h08,8'h04,8'h02}, '{8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h7F,8'h41,8'h5D,8'h41,8'h7F}
    };

    function automatic logic [5:0] font_index(input logic [7:0] ch);
        logic [7:0] up;
        logic [5:0] idx;
        up = ch;
        if (ch inside {[8'h61:8'h7A]}) up = ch - 8'h20;
        if (up inside {[8'h30:8'h39]}) begin
            idx = 6'(up - 8'h30);
        end else if (up inside {[8'h41:8'h5A]}) begin
            idx = 6'(up - 8'h41 + 8'd10);
        end else begin
            case (up)
                8'h3A:   idx = IDX_COLON;
                8'h2D:   idx = IDX_DASH;
                8'h2E:   idx = IDX_DOT;
                8'h25:   idx = IDX_PCT;
                8'h2F:   idx = IDX_SLASH;
                8'h20:   idx = IDX_SPACE;
                default: idx = IDX_BOX;
            endcase
        end
        return idx;
    endfunction

    function automatic logic [7:0] font_col(input logic [5:0] idx, input logic [2:0] col);
        logic [7:0] g;
        g = 8'h00;
        if (idx < 6'(GLYPH_COUNT) && col < 3'(GLYPH_COLS)) g = FONT_ROM[idx][col];
        return g;
    endfunction

    // each lit row becomes a run of scale bits
    function automatic logic [EXP_W-1:0] expand_col(input logic [6:0] g, input logic [2:0] s);
        logic [EXP_W-1:0] e;
        logic [EXP_W-1:0] run;
        e   = '0;
        run = (EXP_W'(1) << s) - EXP_W'(1);
        for (int r = GLYPH_ROWS - 1; r >= 0; r--) begin
            e = (e << s) | (g[r] ? run : '0);
        end
        return e;
    endfunction

endpackage

// File: rtl/tgfr_mac.sv
// shared multiply-add unit for the centering arithmetic
module tgfr_mac (
    input  logic [tgfr_pkg::MAC_A_W-1:0]        i_a,
    input  logic [tgfr_pkg::PITCH_W-1:0]        i_b,
    input  logic signed [tgfr_pkg::COORD_W-1:0] i_c,
    output logic signed [tgfr_pkg::COORD_W-1:0] o_sum
);
    import tgfr_pkg::*;

    logic [MAC_A_W+PITCH_W-1:0] w_prod;

    assign w_prod = i_a * i_b;
    assign o_sum  = $signed(COORD_W'(w_prod)) + i_c;

endmodule

// File: rtl/tgfr_frame_mem.sv
// page-organized framebuffer memory, one write and one registered read port
module tgfr_frame_mem (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [tgfr_pkg::FB_ADDR_W-1:0]  i_waddr,
    input  logic [7:0]                      i_wdata,
    input  logic [tgfr_pkg::FB_ADDR_W-1:0]  i_raddr,
    output logic [7:0]                      o_rdata
);
    import tgfr_pkg::*;

    logic [7:0] r_mem [FB_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/text_glyph_framebuffer_renderer_core.sv
// glyph renderer top level: apb register, sequencer and read-modify-write datapath
// clear request: one framebuffer byte written per cycle
// throughput: one item at a time, busy high until the item's result strobe is issued
// reset: clearing pass with busy high; the receiver cannot stall results
module text_glyph_framebuffer_renderer_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  tgfr_pkg::t_req  i_req,
    output logic            o_res_valid,
    output tgfr_pkg::t_res  o_res,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import tgfr_pkg::*;

    t_state r_state, n_state;

    logic [FB_ADDR_W-1:0]      r_clr_idx, n_clr_idx;
    logic                      r_clr_req, n_clr_req;
    logic [7:0]                r_cursor, n_cursor;
    logic                      r_stopped, n_stopped;
    logic [6:0]                r_tab;
    logic                      r_out_valid, n_out_valid;
    t_res                      r_out, n_out;

    logic [5:0]                r_glyph, n_glyph;
    logic [2:0]                r_scale, n_scale;
    logic [3:0]                r_spacing, n_spacing;
    logic [4:0]                r_len, n_len;
    logic [3:0]                r_pos, n_pos;
    logic [2:0]                r_top_bits, n_top_bits;
    logic                      r_plain, n_plain;
    logic [PITCH_W-1:0]        r_pitch, n_pitch;
    logic signed [COORD_W-1:0] r_acc, n_acc;
    logic signed [COORD_W-1:0] r_col_x, n_col_x;
    logic [2:0]                r_c, n_c;
    logic [DX_W-1:0]           r_dx, n_dx;
    logic [FB_PAGE_W-1:0]      r_page, n_page;
    logic [FB_PAGE_W-1:0]      r_pg_first, n_pg_first;
    logic [FB_PAGE_W-1:0]      r_pg_last, n_pg_last;
    logic [PG_OFF_W-1:0]       r_pg_off, n_pg_off;

    logic                      w_accept;
    logic                      w_cfg_wr;
    logic [7:0]                w_cur0;
    logic                      w_stop0;
    logic [8:0]                w_cur_adv;
    logic [2:0]                w_scale_in;
    logic [6:0]                w_last_row;
    logic [FB_PAGE_W-1:0]      w_last_pg;
    logic                      w_col_ok;
    logic                      w_last_col;
    logic                      w_last_page;
    logic [7:0]                w_gcol;
    logic [EXP_W-1:0]          w_exp;
    logic [SHIFT_W-1:0]        w_shift;
    logic [7:0]                w_mask;
    logic signed [COORD_W-1:0] w_diff;
    logic signed [COORD_W-1:0] w_half;

    logic [MAC_A_W-1:0]        w_mac_a;
    logic [PITCH_W-1:0]        w_mac_b;
    logic signed [COORD_W-1:0] w_mac_c;
    logic signed [COORD_W-1:0] w_mac_sum;

    logic                      w_we;
    logic [FB_ADDR_W-1:0]      w_waddr;
    logic [7:0]                w_wdata;
    logic [FB_ADDR_W-1:0]      w_raddr;
    logic [7:0]                w_rdata;

    tgfr_mac u_mac (
        .i_a   (w_mac_a),
        .i_b   (w_mac_b),
        .i_c   (w_mac_c),
        .o_sum (w_mac_sum)
    );

    tgfr_frame_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // apb register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_TAB_COLUMN) ? {25'd0, r_tab} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab <= 7'(TAB_RESET);
        end else if (w_cfg_wr && paddr[2] == REG_TAB_COLUMN) begin
            r_tab <= pwdata[6:0];
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && !busy;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // text cursor view at accept
    assign w_cur0    = i_req.line_start ? 8'd0 : r_cursor;
    assign w_stop0   = i_req.line_start ? 1'b0 : r_stopped;
    assign w_cur_adv = {1'b0, w_cur0} + 9'(TEXT_ADVANCE);

    assign w_scale_in = (i_req.glyph_scale == 3'd0) ? 3'd1 :
                        (i_req.glyph_scale > 3'(MAX_SCALE)) ? 3'(MAX_SCALE) :
                        i_req.glyph_scale;
    assign w_last_row = {1'b0, i_req.top_y} + 7'({w_scale_in, 3'b000}) - 7'(w_scale_in) - 7'd1;
    assign w_last_pg  = (w_last_row[6:3] > 4'(FB_PAGES - 1)) ? FB_PAGE_W'(FB_PAGES - 1)
                                                           : FB_PAGE_W'(w_last_row[6:3]);

    // column geometry
    assign w_col_ok    = (r_col_x >= 0) && (r_col_x < COORD_W'(FB_WIDTH));
    assign w_last_col  = (r_c == 3'(GLYPH_COLS - 1)) && (r_dx == DX_W'(r_scale - 3'd1));
    assign w_last_page = (r_page == r_pg_last);
    assign w_gcol      = font_col(r_glyph, r_c);
    assign w_exp       = expand_col(w_gcol[6:0], r_scale);
    assign w_shift     = SHIFT_W'(w_exp) << r_top_bits;
    assign w_mask      = w_shift[{r_pg_off, 3'b000} +: 8];

    assign w_diff = COORD_W'(FB_WIDTH) - r_acc;
    assign w_half = (w_diff < 0) ? ((w_diff + COORD_W'(1)) >>> 1) : (w_diff >>> 1);

    // shared multiply-add operand select
    always_comb begin
        w_mac_a = MAC_A_W'(GLYPH_COLS);
        w_mac_b = PITCH_W'(r_scale);
        w_mac_c = COORD_W'(r_spacing);
        case (r_state)
            S_TOTAL: begin
                w_mac_a = r_len;
                w_mac_b = r_pitch;
                w_mac_c = -COORD_W'(r_spacing);
            end
            S_XPOS: begin
                w_mac_a = MAC_A_W'(r_pos);
                w_mac_b = r_pitch;
                w_mac_c = r_acc;
            end
            default: begin
                w_mac_a = MAC_A_W'(GLYPH_COLS);
                w_mac_b = PITCH_W'(r_scale);
                w_mac_c = COORD_W'(r_spacing);
            end
        endcase
    end

    // memory ports
    always_comb begin
        w_raddr = {r_page, r_col_x[FB_COL_W-1:0]};
        if (r_state == S_IDLE) w_raddr = i_req.read_index[FB_ADDR_W-1:0];
        w_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
        w_waddr = (r_state == S_CLEAR) ? r_clr_idx : {r_page, r_col_x[FB_COL_W-1:0]};
        if (r_state == S_CLEAR) begin
            w_wdata = 8'h00;
        end else if (r_plain) begin
            w_wdata = {w_rdata[7], w_gcol[6:0]};
        end else begin
            w_wdata = w_rdata | w_mask;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.req_type)
                        REQ_CLEAR:  n_state = S_CLEAR;
                        REQ_READ:   n_state = S_RD_DATA;
                        REQ_SCALED: n_state = S_PITCH;
                        default: begin
                            if (!w_stop0 && i_req.char_code != TAB_CODE
                                && w_cur0 <= 8'(FB_WIDTH - 5)) begin
                                n_state = S_COL;
                            end
                        end
                    endcase
                end
            end
            S_CLEAR:   if (r_clr_idx == FB_ADDR_W'(FB_BYTES - 1)) n_state = S_IDLE;
            S_RD_DATA: n_state = S_IDLE;
            S_PITCH:   n_state = S_TOTAL;
            S_TOTAL:   n_state = S_ORIGIN;
            S_ORIGIN:  n_state = S_XPOS;
            S_XPOS:    n_state = S_COL;
            S_COL: begin
                if (w_col_ok) n_state = S_READ;
                else if (w_last_col) n_state = S_IDLE;
            end
            S_READ:    n_state = S_WRITE;
            S_WRITE: begin
                if (!w_last_page) n_state = S_READ;
                else if (w_last_col) n_state = S_IDLE;
                else n_state = S_COL;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_clr_idx   = r_clr_idx;
        n_clr_req   = r_clr_req;
        n_cursor    = r_cursor;
        n_stopped   = r_stopped;
        n_out_valid = 1'b0;
        n_out       = r_out;
        n_glyph     = r_glyph;
        n_scale     = r_scale;
        n_spacing   = r_spacing;
        n_len       = r_len;
        n_pos       = r_pos;
        n_top_bits  = r_top_bits;
        n_plain     = r_plain;
        n_pitch     = r_pitch;
        n_acc       = r_acc;
        n_col_x     = r_col_x;
        n_c         = r_c;
        n_dx        = r_dx;
        n_page      = r_page;
        n_pg_first  = r_pg_first;
        n_pg_last   = r_pg_last;
        n_pg_off    = r_pg_off;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_glyph = font_index(i_req.char_code);
                    n_c     = 3'd0;
                    n_dx    = '0;
                    case (i_req.req_type)
                        REQ_CLEAR: begin
                            n_clr_idx = '0;
                            n_clr_req = 1'b1;
                        end
                        REQ_READ: begin
                        end
                        REQ_SCALED: begin
                            n_scale    = w_scale_in;
                            n_spacing  = i_req.glyph_spacing;
                            n_len      = i_req.text_length;
                            n_pos      = i_req.char_position;
                            n_top_bits = i_req.top_y[2:0];
                            n_pg_first = FB_PAGE_W'(i_req.top_y[5:3]);
                            n_pg_last  = w_last_pg;
                            n_plain    = 1'b0;
                        end
                        default: begin
                            n_cursor  = w_cur0;
                            n_stopped = w_stop0;
                            n_out     = '0;
                            if (w_stop0) begin
                                n_out_valid = 1'b1;
                            end else if (i_req.char_code == TAB_CODE) begin
                                n_cursor    = {1'b0, r_tab};
                                n_out_valid = 1'b1;
                            end else if (w_cur0 > 8'(FB_WIDTH - 5)) begin
                                n_stopped   = 1'b1;
                                n_out_valid = 1'b1;
                            end else begin
                                n_cursor   = w_cur_adv[8] ? 8'(CURSOR_MAX) : w_cur_adv[7:0];
                                n_col_x    = COORD_W'(w_cur0);
                                n_scale    = 3'd1;
                                n_top_bits = 3'd0;
                                n_pg_first = FB_PAGE_W'(i_req.text_line);
                                n_pg_last  = FB_PAGE_W'(i_req.text_line);
                                n_plain    = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + FB_ADDR_W'(1);
                if (r_clr_idx == FB_ADDR_W'(FB_BYTES - 1)) begin
                    n_clr_req   = 1'b0;
                    n_out_valid = r_clr_req;
                    n_out       = '0;
                end
            end
            S_RD_DATA: begin
                n_out_valid = 1'b1;
                n_out       = '{read_data: w_rdata, char_drawn: 1'b0};
            end
            S_PITCH:  n_pitch = w_mac_sum[PITCH_W-1:0];
            S_TOTAL:  n_acc = w_mac_sum;
            S_ORIGIN: n_acc = w_half;
            S_XPOS:   n_col_x = w_mac_sum;
            S_COL: begin
                n_page   = r_pg_first;
                n_pg_off = '0;
                if (!w_col_ok) begin
                    n_col_x = r_col_x + COORD_W'(1);
                    if (r_dx == DX_W'(r_scale - 3'd1)) begin
                        n_dx = '0;
                        n_c  = r_c + 3'd1;
                    end else begin
                        n_dx = r_dx + DX_W'(1);
                    end
                    if (w_last_col) begin
                        n_out_valid = 1'b1;
                        n_out       = '{read_data: 8'h00, char_drawn: 1'b1};
                    end
                end
            end
            S_WRITE: begin
                if (!w_last_page) begin
                    n_page   = r_page + FB_PAGE_W'(1);
                    n_pg_off = r_pg_off + PG_OFF_W'(1);
                end else begin
                    n_col_x = r_col_x + COORD_W'(1);
                    if (r_dx == DX_W'(r_scale - 3'd1)) begin
                        n_dx = '0;
                        n_c  = r_c + 3'd1;
                    end else begin
                        n_dx = r_dx + DX_W'(1);
                    end
                    if (w_last_col) begin
                        n_out_valid = 1'b1;
                        n_out       = '{read_data: 8'h00, char_drawn: 1'b1};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_clr_req   <= 1'b0;
            r_cursor    <= 8'd0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_clr_req   <= n_clr_req;
            r_cursor    <= n_cursor;
            r_stopped   <= n_stopped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_glyph    <= n_glyph;
        r_scale    <= n_scale;
        r_spacing  <= n_spacing;
        r_len      <= n_len;
        r_pos      <= n_pos;
        r_top_bits <= n_top_bits;
        r_plain    <= n_plain;
        r_pitch    <= n_pitch;
        r_acc      <= n_acc;
        r_col_x    <= n_col_x;
        r_c        <= n_c;
        r_dx       <= n_dx;
        r_page     <= n_page;
        r_pg_first <= n_pg_first;
        r_pg_last  <= n_pg_last;
        r_pg_off   <= n_pg_off;
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_CLEAR))
        else $error("reset did not start the clearing pass");

    a_write_states: assert property (@(posedge i_clk)
        w_we |-> (r_state == S_CLEAR || r_state == S_WRITE))
        else $error("framebuffer written outside clear or write states");

    a_read_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req.req_type == REQ_READ |=> (r_state == S_RD_DATA))
        else $error("read item did not go to read data state");

    a_drawn_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.char_drawn |-> (o_res.read_data == 8'h00))
        else $error("drawn item carries read data");

    a_page_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WRITE |-> (r_pg_off < PG_OFF_W'(PG_SPAN)))
        else $error("page offset beyond glyph span");

endmodule

// File: tb/text_glyph_framebuffer_renderer_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the glyph renderer core against a shadow framebuffer
module text_glyph_framebuffer_renderer_core_tb;
    import tgfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1100;
    localparam logic [2:0] ADDR_TAB_COLUMN = 3'(4 * REG_TAB_COLUMN);

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        i_req;
    logic        o_res_valid;
    t_res        o_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [7:0]  shadow_fb [FB_BYTES];
    logic [7:0]  shadow_cursor;
    logic        shadow_stopped;
    logic [6:0]  shadow_tab;
    t_res        readback_q [$];
    int          err_count = 0;
    int          stall_cycles = 0;
    bit          idle_en;
    int          quiet_left;

    text_glyph_framebuffer_renderer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // column c sits in bits [39-8c -: 8], row r is bit r of its column
    function automatic logic [39:0] glyph_of(input logic [7:0] ch);
        logic [7:0]  up;
        logic [39:0] g;
        up = ch;
        if (ch >= "a" && ch <= "z") up = ch - ("a" - "A");
        case (up)
            "0": g = 40'h3E5149453E;
            "1": g = 40'h00427F4000;
            "2": g = 40'h4261514946;
            "3": g = 40'h2141454B31;
            "4": g = 40'h1814127F10;
            "5": g = 40'h2745454539;
            "6": g = 40'h3C4A494930;
            "7": g = 40'h0171090503;
            "8": g = 40'h3649494936;
            "9": g = 40'h064949291E;
            "A": g = 40'h7E1111117E;
            "B": g = 40'h7F49494936;
            "C": g = 40'h3E41414122;
            "D": g = 40'h7F4141221C;
            "E": g = 40'h7F49494941;
            "F": g = 40'h7F09090901;
            "G": g = 40'h3E4149497A;
            "H": g = 40'h7F0808087F;
            "I": g = 40'h00417F4100;
            "J": g = 40'h2040413F01;
            "K": g = 40'h7F08142241;
            "L": g = 40'h7F40404040;
            "M": g = 40'h7F020C027F;
            "N": g = 40'h7F0408107F;
            "O": g = 40'h3E4141413E;
            "P": g = 40'h7F09090906;
            "Q": g = 40'h3E4151215E;
            "R": g = 40'h7F09192946;
            "S": g = 40'h4649494931;
            "T": g = 40'h01017F0101;
            "U": g = 40'h3F4040403F;
            "V": g = 40'h1F2040201F;
            "W": g = 40'h3F4038403F;
            "X": g = 40'h6314081463;
            "Y": g = 40'h0708700807;
            "Z": g = 40'h6151494543;
            ":": g = 40'h0036360000;
            "-": g = 40'h0808080808;
            ".": g = 40'h0060600000;
            "%": g = 40'h6313086463;
            "/": g = 40'h2010080402;
            " ": g = 40'h0000000000;
            default: g = 40'h7F415D417F;
        endcase
        return g;
    endfunction

    function automatic void plot(input int x, input int y, input bit lit);
        int idx;
        if (x < 0 || x >= FB_WIDTH || y < 0 || y >= FB_HEIGHT) return;
        idx = x + (y / 8) * FB_WIDTH;
        shadow_fb[idx][y % 8] = lit;
    endfunction

    function automatic t_res mirror_render(input t_req rq);
        t_res        res;
        logic [39:0] g;
        int          scale;
        int          pitch;
        int          total;
        int          x0;
        int          y0;
        int          nx;
        res = '0;
        g = glyph_of(rq.char_code);
        case (rq.req_type)
            REQ_CLEAR: begin
                for (int i = 0; i < FB_BYTES; i++) shadow_fb[i] = '0;
            end
            REQ_TEXT: begin
                if (rq.line_start) begin
                    shadow_cursor = '0;
                    shadow_stopped = 1'b0;
                end
                if (!shadow_stopped) begin
                    if (rq.char_code == TAB_CODE) begin
                        shadow_cursor = 8'(shadow_tab);
                    end else if (int'(shadow_cursor) > FB_WIDTH - GLYPH_COLS) begin
                        shadow_stopped = 1'b1;
                    end else begin
                        y0 = int'(rq.text_line) * 8;
                        for (int c = 0; c < GLYPH_COLS; c++)
                            for (int r = 0; r < GLYPH_ROWS; r++)
                                plot(int'(shadow_cursor) + c, y0 + r, g[32 - 8 * c + r]);
                        nx = int'(shadow_cursor) + TEXT_ADVANCE;
                        shadow_cursor = 8'((nx > CURSOR_MAX) ? CURSOR_MAX : nx);
                        res.char_drawn = 1'b1;
                    end
                end
            end
            REQ_SCALED: begin
                scale = int'(rq.glyph_scale);
                if (scale < 1) scale = 1;
                if (scale > MAX_SCALE) scale = MAX_SCALE;
                pitch = GLYPH_COLS * scale + int'(rq.glyph_spacing);
                total = int'(rq.text_length) * pitch - int'(rq.glyph_spacing);
                x0 = (FB_WIDTH - total) / 2 + int'(rq.char_position) * pitch;
                y0 = int'(rq.top_y);
                for (int c = 0; c < GLYPH_COLS; c++)
                    for (int r = 0; r < GLYPH_ROWS; r++)
                        if (g[32 - 8 * c + r])
                            for (int dx = 0; dx < scale; dx++)
                                for (int dy = 0; dy < scale; dy++)
                                    plot(x0 + c * scale + dx, y0 + r * scale + dy, 1'b1);
                res.char_drawn = 1'b1;
            end
            REQ_READ: begin
                if (int'(rq.read_index) < FB_BYTES) res.read_data = shadow_fb[rq.read_index];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_req rand_req();
        logic [63:0] raw;
        t_req        rq;
        raw = {$urandom, $urandom};
        rq = raw[$bits(t_req)-1:0];
        return rq;
    endfunction

    function automatic logic [7:0] pick_char();
        logic [7:0] ch;
        case ($urandom_range(0, 9))
            0, 1, 2: ch = 8'("A" + $urandom_range(0, 25));
            3:       ch = 8'("a" + $urandom_range(0, 25));
            4, 5:    ch = 8'("0" + $urandom_range(0, 9));
            6: begin
                case ($urandom_range(0, 5))
                    0:       ch = ":";
                    1:       ch = "-";
                    2:       ch = ".";
                    3:       ch = "%";
                    4:       ch = "/";
                    default: ch = " ";
                endcase
            end
            7:       ch = TAB_CODE;
            default: ch = 8'($urandom_range(0, 255));
        endcase
        return ch;
    endfunction

    function automatic t_req text_req(input logic [7:0] ch, input int line, input bit first);
        t_req rq;
        rq = rand_req();
        rq.req_type = REQ_TEXT;
        rq.char_code = ch;
        rq.text_line = 3'(line);
        rq.line_start = first;
        return rq;
    endfunction

    function automatic t_req scaled_req(input logic [7:0] ch, input int s, input int sp,
                                        input int len, input int pos, input int top);
        t_req rq;
        rq = rand_req();
        rq.req_type = REQ_SCALED;
        rq.char_code = ch;
        rq.glyph_scale = 3'(s);
        rq.glyph_spacing = 4'(sp);
        rq.text_length = 5'(len);
        rq.char_position = 4'(pos);
        rq.top_y = 6'(top);
        return rq;
    endfunction

    function automatic t_req read_req(input int idx);
        t_req rq;
        rq = rand_req();
        rq.req_type = REQ_READ;
        rq.read_index = 10'(idx);
        return rq;
    endfunction

    function automatic t_req clear_req();
        t_req rq;
        rq = rand_req();
        rq.req_type = REQ_CLEAR;
        return rq;
    endfunction

    // entered and left at a falling edge; start stays high unless a gap follows
    task automatic send_item(input t_req rq);
        int gap;
        start <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        readback_q.push_back(mirror_render(rq));
        @(negedge i_clk);
        gap = 0;
        if (quiet_left > 0) begin
            quiet_left--;
        end else if (idle_en) begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = $urandom_range(1, 13);
                3:       quiet_left = $urandom_range(10, 40);
                default: gap = 0;
            endcase
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (readback_q.size() != 0 || busy !== 1'b0) @(negedge i_clk);
    endtask

    task automatic program_tab(input logic [6:0] col);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_TAB_COLUMN;
        pwdata <= {25'($urandom_range(0, 32'h01FF_FFFF)), col};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        shadow_tab = col;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        if (prdata !== 32'(shadow_tab)) begin
            $error("tab_column expected %0h actual %0h", 32'(shadow_tab), prdata);
            err_count++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_reset_clear();
        wait_idle();
        send_item(read_req(0));
        send_item(read_req(FB_BYTES - 1));
        send_item(read_req($urandom_range(0, FB_BYTES - 1)));
    endtask

    task automatic test_text_glyphs();
        logic [7:0] chars [12];
        chars = '{"a", "Z", "0", "9", ":", "-", ".", "%", "/", " ", 8'h00, 8'hFF};
        for (int k = 0; k < 12; k++) send_item(text_req(chars[k], 0, k == 0));
        send_item(text_req(TAB_CODE, 7, 1'b1));
        send_item(text_req("8", 7, 1'b0));
        send_item(read_req(6));
        send_item(read_req(7 * FB_WIDTH + TAB_RESET + 1));
    endtask

    task automatic test_scaled_edges();
        send_item(scaled_req("W", 0, 0, 1, 0, 0));
        send_item(scaled_req("M", 7, 15, 16, 15, 63));
        send_item(scaled_req("4", 4, 3, 0, 15, 10));
        send_item(scaled_req("x", 5, 0, 31, 0, 20));
        send_item(scaled_req("%", 4, 0, 1, 0, 40));
        send_item(scaled_req("B", 4, 0, 7, 0, 8));
        send_item(scaled_req("k", 2, 1, 3, 2, 63));
        send_item(read_req(5 * FB_WIDTH + 60));
        send_item(read_req(1 * FB_WIDTH + 0));
    endtask

    task automatic test_clear_and_cursor();
        send_item(clear_req());
        send_item(read_req(5 * FB_WIDTH + 60));
        send_item(text_req("K", 3, 1'b0));
        send_item(read_req(3 * FB_WIDTH + TAB_RESET + 6));
    endtask

    task automatic test_tab_and_stop();
        wait_idle();
        program_tab(7'd127);
        send_item(text_req(TAB_CODE, 2, 1'b1));
        send_item(text_req("X", 2, 1'b0));
        send_item(text_req(TAB_CODE, 2, 1'b0));
        send_item(text_req("Y", 2, 1'b0));
        send_item(text_req("Q", 2, 1'b1));
        wait_idle();
        program_tab(7'd0);
        send_item(text_req("A", 4, 1'b1));
        send_item(text_req(TAB_CODE, 4, 1'b0));
        send_item(text_req("B", 4, 1'b0));
        send_item(read_req(4 * FB_WIDTH));
    endtask

    task automatic run_random(input int count);
        t_req rq;
        int   sent;
        int   roll;
        int   len;
        int   line;
        int   pos_max;
        bit   broken;
        sent = 0;
        while (sent < count) begin
            roll = $urandom_range(0, 99);
            rq = rand_req();
            if (roll < 2) begin
                rq.req_type = REQ_CLEAR;
                send_item(rq);
                sent++;
            end else if (roll < 32) begin
                rq.req_type = REQ_READ;
                send_item(rq);
                sent++;
            end else if (roll < 60) begin
                rq.req_type = REQ_SCALED;
                rq.char_code = pick_char();
                if ($urandom_range(0, 9) != 0) rq.glyph_scale = 3'($urandom_range(1, MAX_SCALE));
                if ($urandom_range(0, 9) != 0) rq.text_length = 5'($urandom_range(1, 16));
                if (rq.text_length != 0 && $urandom_range(0, 9) < 7) begin
                    pos_max = int'(rq.text_length) - 1;
                    if (pos_max > 15) pos_max = 15;
                    rq.char_position = 4'($urandom_range(0, pos_max));
                end
                send_item(rq);
                sent++;
            end else if (roll < 64) begin
                rq.req_type = REQ_TEXT;
                rq.char_code = pick_char();
                send_item(rq);
                sent++;
            end else begin
                len = $urandom_range(1, 26);
                line = $urandom_range(0, 7);
                broken = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < len; k++)
                    send_item(text_req(pick_char(), line, (k == 0) && !broken));
                repeat (2) send_item(read_req(line * FB_WIDTH + $urandom_range(0, FB_WIDTH - 1)));
                sent += len + 2;
            end
        end
    endtask

    task automatic test_random_phases();
        logic [6:0] cols [5];
        cols = '{7'(TAB_RESET), 7'd0, 7'd127, 7'($urandom), 7'($urandom)};
        for (int p = 0; p < 5; p++) begin
            wait_idle();
            program_tab(cols[p]);
            run_random(280);
        end
    endtask

    task automatic test_no_idle();
        wait_idle();
        idle_en = 1'b0;
        quiet_left = 0;
        program_tab(7'($urandom));
        run_random(150);
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_valid === 1'b1) begin
            if (readback_q.size() == 0) begin
                $error("result with no item pending: read_data %0h char_drawn %0b",
                       o_res.read_data, o_res.char_drawn);
                err_count++;
            end else begin
                want = readback_q.pop_front();
                if (o_res.read_data !== want.read_data) begin
                    $error("read_data expected %0h actual %0h", want.read_data, o_res.read_data);
                    err_count++;
                end
                if (o_res.char_drawn !== want.char_drawn) begin
                    $error("char_drawn expected %0b actual %0b", want.char_drawn, o_res.char_drawn);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid === 1'b1 || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_en = 1'b1;
        quiet_left = 0;
        for (int i = 0; i < FB_BYTES; i++) shadow_fb[i] = '0;
        shadow_cursor = '0;
        shadow_stopped = 1'b0;
        shadow_tab = 7'(TAB_RESET);
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_clear();
        test_text_glyphs();
        test_scaled_edges();
        test_clear_and_cursor();
        test_tab_and_stop();
        test_random_phases();
        test_no_idle();

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (readback_q.size() != 0) begin
            $error("results missing: %0d items still pending", readback_q.size());
            err_count++;
        end
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
